[rtl/rational_arith_unit_defines.svh]
// Assertion macros shared by the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication check.
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rational_arith_unit check failed");

// Next-cycle implication check.
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rational_arith_unit check failed");

`endif

[rtl/rau_pkg.sv]
// Types and constants of the rational arithmetic unit.
package rau_pkg;

   localparam int WIDTH_DEF = 32;

   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_DIV = 3'd3;
   localparam logic [2:0] MODE_CMP = 3'd4;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] a_num;
      logic [30:0]        a_den;
      logic signed [31:0] b_num;
      logic [30:0]        b_den;
   } op_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic               less_than;
      logic               overflow;
      logic               div_zero;
   } res_type;

   typedef struct packed {
      logic start;
      logic ack;
   } ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } sts_type;

endpackage

[rtl/rau_if.sv]
// Word channels of the rational arithmetic unit.
interface rau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic signed [31:0] a_num;
   logic [30:0]        a_den;
   logic signed [31:0] b_num;
   logic [30:0]        b_den;

   modport source(output valid, mode, a_num, a_den, b_num, b_den, input ready);
   modport sink(input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] res_num;
   logic [30:0]        res_den;
   logic               less_than;
   logic               overflow;
   logic               div_zero;

   modport source(output valid, res_num, res_den, less_than, overflow, div_zero,
                  input ready);
   modport sink(input valid, res_num, res_den, less_than, overflow, div_zero,
                output ready);
endinterface

[rtl/rau_engine.sv]
// Sequenced multiplier, binary gcd and restoring divider of the rational unit.
module rau_engine #(
   parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  rau_pkg::ctl_type ctl,
   input  rau_pkg::op_type  op,
   output rau_pkg::sts_type sts,
   output rau_pkg::res_type res
);

   localparam int DW = 2 * WIDTH;
   localparam int MW = WIDTH + 1;
   localparam int KW = $clog2(DW + 1);
   localparam int CW = $clog2(DW);
   localparam logic [DW-1:0] HALF = DW'(1) << (WIDTH - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_CMP, S_GCD, S_DIVN, S_DIVD, S_FIN, S_HOLD
   } state_type;

   state_type              state_ff, state_in;
   rau_pkg::op_type        op_ff, op_in;
   rau_pkg::res_type       res_ff, res_in;
   logic signed [DW-1:0]   p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic [DW-1:0]          u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic [DW-1:0]          mn_ff, mn_in, md_ff, md_in, qn_ff, qn_in;
   logic [DW-1:0]          rem_ff, rem_in, dq_ff, dq_in;
   logic [KW-1:0]          k_ff, k_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;

   logic signed [MW-1:0]   an, ad, bn, bd, mul_a, mul_b;
   logic signed [2*MW-1:0] prod;
   logic signed [DW-1:0]   nval;
   logic [DW-1:0]          gsel, rem_sh, sq;
   logic                   ge;

   assign an = {op_ff.a_num[WIDTH-1], op_ff.a_num[WIDTH-1:0]};
   assign bn = {op_ff.b_num[WIDTH-1], op_ff.b_num[WIDTH-1:0]};
   assign ad = {2'b00, op_ff.a_den[WIDTH-2:0]};
   assign bd = {2'b00, op_ff.b_den[WIDTH-2:0]};
   assign prod = mul_a * mul_b;
   assign rem_sh = {rem_ff[DW-2:0], dq_ff[DW-1]};
   assign ge = rem_sh >= g_ff;
   assign sq = neg_ff ? (DW'(0) - qn_ff) : qn_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      res_in   = res_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      p3_in    = p3_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      g_in     = g_ff;
      mn_in    = mn_ff;
      md_in    = md_ff;
      qn_in    = qn_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      mul_a    = an;
      mul_b    = bd;
      nval     = p1_ff;
      gsel     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               op_in = op;
               if (op.mode > rau_pkg::MODE_CMP) begin
                  res_in   = '0;
                  state_in = S_HOLD;
               end else begin
                  state_in = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            if (op_ff.mode == rau_pkg::MODE_MUL) begin
               mul_b = bn;
            end
            p1_in = prod[DW-1:0];
            if (op_ff.mode == rau_pkg::MODE_MUL || op_ff.mode == rau_pkg::MODE_DIV) begin
               state_in = S_MUL3;
            end else begin
               state_in = S_MUL2;
            end
         end
         S_MUL2: begin
            mul_a = bn;
            mul_b = ad;
            p2_in = prod[DW-1:0];
            state_in = (op_ff.mode == rau_pkg::MODE_CMP) ? S_CMP : S_MUL3;
         end
         S_MUL3: begin
            mul_a = ad;
            mul_b = (op_ff.mode == rau_pkg::MODE_DIV) ? bn : bd;
            p3_in = prod[DW-1:0];
            state_in = S_SUM;
         end
         S_SUM: begin
            case (op_ff.mode)
               rau_pkg::MODE_ADD: nval = p1_ff + p2_ff;
               rau_pkg::MODE_SUB: nval = p1_ff - p2_ff;
               default:           nval = p1_ff;
            endcase
            mn_in  = nval[DW-1] ? (DW'(0) - nval) : nval;
            md_in  = p3_ff[DW-1] ? (DW'(0) - p3_ff) : p3_ff;
            neg_in = nval[DW-1] ^ p3_ff[DW-1];
            u_in   = mn_in;
            v_in   = md_in;
            k_in   = '0;
            state_in = S_GCD;
         end
         S_CMP: begin
            res_in = '0;
            if (an < 0 && bn > 0) begin
               res_in.less_than = 1'b1;
            end else if (an > 0 && bn < 0) begin
               res_in.less_than = 1'b0;
            end else begin
               res_in.less_than = p1_ff < p2_ff;
            end
            state_in = S_HOLD;
         end
         S_GCD: begin
            if (u_ff == '0 || v_ff == '0) begin
               gsel     = (u_ff == '0) ? (v_ff << k_ff) : (u_ff << k_ff);
               g_in     = (gsel == '0) ? DW'(1) : gsel;
               dq_in    = mn_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIVN;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_in = (u_ff - v_ff) >> 1;
            end else begin
               v_in = (v_ff - u_ff) >> 1;
            end
         end
         S_DIVN, S_DIVD: begin
            rem_in = ge ? (rem_sh - g_ff) : rem_sh;
            dq_in  = {dq_ff[DW-2:0], ge};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DW - 1)) begin
               if (state_ff == S_DIVN) begin
                  qn_in    = {dq_ff[DW-2:0], ge};
                  dq_in    = md_ff;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = S_DIVD;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            res_in.res_num   = 32'($signed(sq[WIDTH-1:0]));
            res_in.res_den   = 31'(dq_ff[WIDTH-2:0]);
            res_in.less_than = 1'b0;
            res_in.overflow  = (neg_ff ? (qn_ff > HALF) : (qn_ff > HALF - DW'(1)))
                               || (dq_ff > HALF - DW'(1));
            res_in.div_zero  = (op_ff.mode == rau_pkg::MODE_DIV) && (bn == '0);
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (ctl.ack) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      res_ff <= res_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      p3_ff  <= p3_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      g_ff   <= g_in;
      mn_ff  <= mn_in;
      md_ff  <= md_in;
      qn_ff  <= qn_in;
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign sts.idle = (state_ff == S_IDLE);
   assign sts.done = (state_ff == S_HOLD);
   assign res      = res_ff;

endmodule

[rtl/rational_arith_unit.sv]
// Top level of the rational arithmetic unit.
// Each request word carries two rationals and a mode (add, subtract, multiply,
// divide or less-than compare) and yields one response word. One word is in
// work at a time and req ready is low until it has moved to the output
// register. A compare cross-multiplies in states S_MUL1 and S_MUL2 and an unused
// mode goes straight to a result with all fields zero. An arithmetic mode
// forms its products on one shared multiplier in states S_MUL1 to S_MUL3
// (S_MUL2 is skipped for multiply and divide), then runs a binary gcd of the
// double-width numerator and denominator magnitudes at one subtract or shift
// per cycle until one of them is zero, then two restoring divisions by the gcd.
`include "rational_arith_unit_defines.svh"

module rational_arith_unit #(
   parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   rau_req_if.sink   req_bus,
   rau_rsp_if.source rsp_bus
);

   rau_pkg::ctl_type ctl;
   rau_pkg::sts_type sts;
   rau_pkg::op_type  op;
   rau_pkg::res_type eng_res;
   rau_pkg::res_type out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   logic             load;

   assign op.mode  = req_bus.mode;
   assign op.a_num = req_bus.a_num;
   assign op.a_den = req_bus.a_den;
   assign op.b_num = req_bus.b_num;
   assign op.b_den = req_bus.b_den;

   assign req_bus.ready = sts.idle;
   assign load          = sts.done && (!out_valid_ff || rsp_bus.ready);
   assign ctl.start     = req_bus.valid && sts.idle;
   assign ctl.ack       = load;

   rau_engine #(.WIDTH(WIDTH)) u_engine (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .op    (op),
      .sts   (sts),
      .res   (eng_res)
   );

   always_comb begin
      out_in       = load ? eng_res : out_ff;
      out_valid_in = load || (out_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.res_num   = out_ff.res_num;
   assign rsp_bus.res_den   = out_ff.res_den;
   assign rsp_bus.less_than = out_ff.less_than;
   assign rsp_bus.overflow  = out_ff.overflow;
   assign rsp_bus.div_zero  = out_ff.div_zero;

   `RAU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)
   `RAU_ASSERT_IMP(a_div_zero_den, clock, reset, rsp_bus.valid && rsp_bus.div_zero, rsp_bus.res_den == 31'd0)
   `RAU_ASSERT_IMP(a_cmp_clean, clock, reset, rsp_bus.valid && rsp_bus.less_than, !rsp_bus.overflow && !rsp_bus.div_zero && rsp_bus.res_den == 31'd0)

endmodule
